// ----- hw/rtl/lge_pkg.sv -----
// shared types and constants for the life grid generation engine
package lge_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int DIM_W     = 7;
  localparam int CMD_W     = 2;
  localparam int COORD_W   = 6;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 4;
  localparam int BIG_W     = 9;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_ROW = 2'd1;
  localparam logic [STAT_W-1:0] ST_COL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 2'd1;

  // b3/s23 neighbor counts
  localparam logic [CNT_W-1:0] NB_BIRTH = 4'd3;
  localparam logic [CNT_W-1:0] NB_KEEP  = 4'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COORD_W-1:0] cell_row;
    logic [COORD_W-1:0] cell_col;
  } lge_in_t;

  typedef struct packed {
    logic              cell_alive;
    logic [STAT_W-1:0] status;
  } lge_out_t;

  // per-cycle control broadcast to every row cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic set;
  } lge_cell_ctl_t;

  // zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
                                                 logic [BIG_W-1:0] maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if ({2'b00, v} > maxv) begin
      res = maxv[DIM_W-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/lge_row_cell.sv -----
// one row of the grid: a row word that shifts toward the head of the ring
module lge_row_cell #(
  parameter int COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lge_pkg::lge_cell_ctl_t ctl,
  input  logic                  row_hit,
  input  logic [COLS-1:0]       col_onehot,
  input  logic [COLS-1:0]       shift_in,
  output logic [COLS-1:0]       word,
  output logic                  rd_bit
);
  import lge_pkg::*;

  logic [COLS-1:0] word_r;
  logic [COLS-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    priority if (ctl.clear) begin
      word_nxt = '0;
    end else if (ctl.shift) begin
      word_nxt = shift_in;
    end else if (ctl.set && row_hit) begin
      word_nxt = word_r | col_onehot;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word   = word_r;
  assign rd_bit = row_hit & (|(word_r & col_onehot));

endmodule

// ----- hw/rtl/lge_rule.sv -----
// b3/s23 update of one row word from its upper, own and lower rows
module lge_rule #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] mid,
  input  logic [COLS-1:0] below,
  input  logic [COLS-1:0] col_mask,
  input  logic            row_active,
  output logic [COLS-1:0] next_row
);
  import lge_pkg::*;

  logic [COLS+1:0] ap;
  logic [COLS+1:0] mp;
  logic [COLS+1:0] bp;

  // inactive columns and the border read as dead
  assign ap = {1'b0, above & col_mask, 1'b0};
  assign mp = {1'b0, mid & col_mask, 1'b0};
  assign bp = {1'b0, below & col_mask, 1'b0};

  for (genvar j = 0; j < COLS; j++) begin : g_col
    logic [CNT_W-1:0] n;
    logic             live;
    assign n = CNT_W'(ap[j]) + CNT_W'(ap[j+1]) + CNT_W'(ap[j+2])
             + CNT_W'(mp[j]) + CNT_W'(mp[j+2])
             + CNT_W'(bp[j]) + CNT_W'(bp[j+1]) + CNT_W'(bp[j+2]);
    assign live = (n == NB_BIRTH) | ((n == NB_KEEP) & mid[j]);
    assign next_row[j] = (row_active & col_mask[j]) ? live : mid[j];
  end

endmodule

// ----- hw/rtl/life_grid_generation_engine.sv -----
// top level: command sequencer, ring of row cells and result register
// latency: clear, set and read give their result the cycle after the item is accepted
// advance gives its result when the S_GEN sweep ends on its last row step
// one item at a time; advance stalls the input for the whole sweep while
//   the row ring rotates once through the rule unit, one row word per cycle
// reset: synchronous active-low; grid cleared, active region 64 x 64 clamped to max
module life_grid_generation_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lge_pkg::lge_in_t                in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lge_pkg::lge_out_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lge_pkg::DIM_W-1:0]       cfg_data
);
  import lge_pkg::*;

  localparam int ROW_CW = $clog2(MAX_ROWS);
  localparam logic [BIG_W-1:0] MAX_R9 = BIG_W'(MAX_ROWS);
  localparam logic [BIG_W-1:0] MAX_C9 = BIG_W'(MAX_COLS);
  localparam logic [ROW_CW-1:0] K_LAST = ROW_CW'(MAX_ROWS - 1);

  typedef enum logic {
    S_IDLE,
    S_GEN
  } state_t;

  state_t            state_r;
  logic              out_valid_r;
  lge_out_t          out_item_r;
  logic [ROW_CW-1:0] k_r;
  logic [MAX_COLS-1:0] prev_r;
  logic [DIM_W-1:0]  rows_r;
  logic [DIM_W-1:0]  cols_r;

  // handshake
  logic accept;
  logic out_free;
  logic in_row_ok;
  logic in_col_ok;

  // ring of row cells, head at index 0
  logic [MAX_COLS-1:0] ring_word [MAX_ROWS];
  logic [MAX_ROWS-1:0] rd_bits;
  logic [MAX_ROWS-1:0] row_hit;
  logic [MAX_COLS-1:0] col_onehot;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] tail_in;
  logic [MAX_COLS-1:0] above_w;
  logic [MAX_COLS-1:0] below_w;
  logic                row_active;
  logic                next_active;
  lge_cell_ctl_t       cell_ctl;

  // the output register frees up when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // the row is checked before the column
  assign in_row_ok = {1'b0, in_item.cell_row} < rows_r;
  assign in_col_ok = {1'b0, in_item.cell_col} < cols_r;

  // column decode and active column mask
  for (genvar j = 0; j < MAX_COLS; j++) begin : g_coldec
    localparam logic [BIG_W-1:0] JJ = BIG_W'(j);
    assign col_onehot[j] = ({3'b000, in_item.cell_col} == JJ);
    assign col_mask[j]   = (JJ < {2'b00, cols_r});
  end

  // broadcast control: clear kills every row, set only hits the addressed one
  always_comb begin
    cell_ctl.clear = accept && (in_item.command == CMD_CLEAR);
    cell_ctl.shift = (state_r == S_GEN);
    cell_ctl.set   = accept && (in_item.command == CMD_SET) && in_row_ok && in_col_ok;
  end

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
    localparam logic [BIG_W-1:0] II = BIG_W'(i);
    logic [MAX_COLS-1:0] shift_src;
    assign row_hit[i] = ({3'b000, in_item.cell_row} == II);
    if (i == MAX_ROWS - 1) begin : g_tail
      assign shift_src = tail_in;
    end else begin : g_mid
      assign shift_src = ring_word[i+1];
    end
    lge_row_cell #(
      .COLS(MAX_COLS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .row_hit   (row_hit[i]),
      .col_onehot(col_onehot),
      .shift_in  (shift_src),
      .word      (ring_word[i]),
      .rd_bit    (rd_bits[i])
    );
  end

  // during a generation at sweep step k the head holds old row k and its
  // neighbor old row k+1; old row k-1 was saved in prev_r
  assign row_active  = {{(BIG_W-ROW_CW){1'b0}}, k_r} < {2'b00, rows_r};
  assign next_active = ({{(BIG_W-ROW_CW){1'b0}}, k_r} + BIG_W'(1)) < {2'b00, rows_r};
  assign above_w     = (k_r == '0) ? '0 : prev_r;
  assign below_w     = next_active ? ring_word[1] : '0;

  lge_rule #(
    .COLS(MAX_COLS)
  ) u_rule (
    .above     (above_w),
    .mid       (ring_word[0]),
    .below     (below_w),
    .col_mask  (col_mask),
    .row_active(row_active),
    .next_row  (tail_in)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_item.command == CMD_STEP) begin
              state_r <= S_GEN;
              k_r     <= '0;
              prev_r  <= '0;
            end else begin
              out_valid_r           <= 1'b1;
              out_item_r.cell_alive <= 1'b0;
              out_item_r.status     <= ST_OK;
              if (in_item.command == CMD_SET || in_item.command == CMD_READ) begin
                priority if (!in_row_ok) begin
                  out_item_r.status <= ST_ROW;
                end else if (!in_col_ok) begin
                  out_item_r.status <= ST_COL;
                end else begin
                  out_item_r.cell_alive <= (in_item.command == CMD_READ) && (|rd_bits);
                end
              end
            end
          end
        end
        S_GEN: begin
          prev_r <= ring_word[0];
          k_r    <= k_r + ROW_CW'(1);
          if (k_r == K_LAST) begin
            state_r               <= S_IDLE;
            k_r                   <= '0;
            out_valid_r           <= 1'b1;
            out_item_r.cell_alive <= 1'b0;
            out_item_r.status     <= ST_OK;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // configuration registers, values clamped on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= clamp_dim(DIM_RESET, MAX_R9);
      cols_r <= clamp_dim(DIM_RESET, MAX_C9);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ACTIVE_ROWS) begin
        rows_r <= clamp_dim(cfg_data, MAX_R9);
      end else if (cfg_index == REG_ACTIVE_COLS) begin
        cols_r <= clamp_dim(cfg_data, MAX_C9);
      end
    end
  end

`ifndef SYNTHESIS
  // no item is taken while the ring rotates
  a_gen_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN) |-> in_stall)
    else $error("item accepted during a generation sweep");

  // the last sweep step always produces a result
  a_gen_completes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN && k_r == K_LAST) |=> (out_valid_r && state_r == S_IDLE))
    else $error("generation sweep ended without a result");

  // an error status never comes with a live cell
  a_err_dead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.status != ST_OK) |-> !out_item_r.cell_alive)
    else $error("error result reports a live cell");

  // active region stays within bounds
  a_dims_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (rows_r != '0) && ({2'b00, rows_r} <= MAX_R9) &&
    (cols_r != '0) && ({2'b00, cols_r} <= MAX_C9))
    else $error("active region out of range");

  // the sweep counter moves only while sweeping
  a_counter_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (k_r == '0))
    else $error("sweep counter not parked while idle");
`endif

endmodule
